FILE: src/fplw_pkg.sv
package fplw_pkg;

  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_TRANSLATE = 2'd1;
  localparam logic [1:0] OP_CHECK     = 2'd2;
  localparam logic [1:0] OP_UNMAP     = 2'd3;

  localparam logic [1:0] MT_4K = 2'd0;
  localparam logic [1:0] MT_2M = 2'd1;
  localparam logic [1:0] MT_1G = 2'd2;

  localparam int unsigned PTE_P  = 0;
  localparam int unsigned PTE_PS = 7;

  localparam int unsigned PAGE_WORDS = 512;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned FRAME_W    = 40;
  localparam int unsigned VA_W       = 48;
  localparam int unsigned PA_W       = 52;
  localparam int unsigned PTE_W      = 64;
  localparam int unsigned ROOT_W     = 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_EVAL,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic issue;
    logic eval;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic issue_done;
    logic eval_done;
  } sts_t;

endpackage

FILE: src/fplw_ram.sv
module fplw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: src/fplw_ctrl.sv
module fplw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  input  fplw_pkg::sts_t sts_i,
  output fplw_pkg::cmd_t cmd_o
);
  import fplw_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        state_d     = sts_i.issue_done ? ST_RESP : ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.eval_done ? ST_RESP : ST_ISSUE;
      end
      ST_RESP: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clr_step, cmd_o.capture, cmd_o.issue, cmd_o.eval, cmd_o.out_load}))
    else $error("more than one datapath command at once");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output beat overwritten before it was taken");

  a_capture_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_ISSUE))
    else $error("captured item not issued");

endmodule

FILE: src/fplw_dp.sv
module fplw_dp #(
  parameter int unsigned PHYS_PAGES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fplw_pkg::cmd_t                    cmd_i,
  output fplw_pkg::sts_t                    sts_o,
  input  logic                              cfg_we_i,
  input  logic [fplw_pkg::ROOT_W-1:0]       cfg_wdata_i,
  input  logic [1:0]                        opcode_i,
  input  logic [fplw_pkg::VA_W-1:0]         virt_addr_i,
  input  logic [1:0]                        map_type_i,
  input  logic [11:0]                       flag_mask_i,
  input  logic [11:0]                       word_index_i,
  input  logic [fplw_pkg::PTE_W-1:0]        word_data_i,
  output logic [fplw_pkg::PA_W-1:0]         phys_addr_o,
  output logic                              hit_o,
  output logic                              range_error_o
);
  import fplw_pkg::*;

  localparam int unsigned MEM_WORDS = PHYS_PAGES * PAGE_WORDS;
  localparam int unsigned FW        = $clog2(PHYS_PAGES);
  localparam int unsigned AW        = FW + IDX_W;

  logic [ROOT_W-1:0] root_q;
  logic [1:0]        op_q;
  logic [VA_W-1:0]   va_q;
  logic [1:0]        type_q;
  logic [11:0]       mask_q;
  logic [11:0]       widx_q;
  logic [PTE_W-1:0]  wdata_q;
  logic [1:0]        lv_q;
  logic [PTE_W-1:0]  e_q;
  logic [AW-1:0]     a_q;
  logic [AW-1:0]     clr_q;
  logic [PA_W-1:0]   res_pa_q;
  logic              res_hit_q, res_rerr_q;
  logic [PA_W-1:0]   out_pa_q;
  logic              out_hit_q, out_rerr_q;

  logic [IDX_W-1:0]   idx;
  logic [FRAME_W-1:0] frame;
  logic               null_ptr, oor, w_in;
  logic [AW-1:0]      walk_addr;
  logic [AW+11:0]     widx_ext;
  logic               issue_done, issue_rerr;
  logic               eval_done, eval_hit, eval_wb;
  logic [PA_W-1:0]    eval_pa;
  logic               res_load;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [PTE_W-1:0]   ram_wdata, rdata;
  logic               pres, psize;

  fplw_ram #(
    .WIDTH (PTE_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (walk_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      clr_q  <= '0;
      lv_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.capture) begin
        lv_q <= '0;
      end else if (cmd_i.eval && !eval_done) begin
        lv_q <= lv_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      va_q    <= virt_addr_i;
      type_q  <= map_type_i;
      mask_q  <= flag_mask_i;
      widx_q  <= word_index_i;
      wdata_q <= word_data_i;
    end
    if (cmd_i.issue) begin
      a_q <= walk_addr;
    end
    if (cmd_i.eval) begin
      e_q <= rdata;
    end
    if (res_load) begin
      if (cmd_i.issue) begin
        res_pa_q   <= '0;
        res_hit_q  <= 1'b0;
        res_rerr_q <= issue_rerr;
      end else begin
        res_pa_q   <= eval_pa;
        res_hit_q  <= eval_hit;
        res_rerr_q <= 1'b0;
      end
    end
    if (cmd_i.out_load) begin
      out_pa_q   <= res_pa_q;
      out_hit_q  <= res_hit_q;
      out_rerr_q <= res_rerr_q;
    end
  end

  always_comb begin
    case (lv_q)
      2'd0:    idx = va_q[47:39];
      2'd1:    idx = va_q[38:30];
      2'd2:    idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  // next table frame comes from the entry read one level up
  assign frame     = (lv_q == 2'd0) ? FRAME_W'(root_q) : e_q[51:12];
  assign null_ptr  = (lv_q != 2'd0) && (op_q != OP_UNMAP) && (frame == '0);
  assign oor       = frame >= FRAME_W'(PHYS_PAGES);
  assign walk_addr = {frame[FW-1:0], idx};
  assign widx_ext  = (AW + 12)'(widx_q);
  assign w_in      = 32'(widx_q) < 32'(MEM_WORDS);

  always_comb begin
    issue_done = 1'b1;
    issue_rerr = 1'b0;
    if (op_q == OP_WRITE) begin
      issue_rerr = !w_in;
    end else if (null_ptr) begin
      issue_rerr = 1'b0;
    end else if (oor) begin
      issue_rerr = 1'b1;
    end else begin
      issue_done = 1'b0;
    end
  end

  assign pres  = rdata[PTE_P];
  assign psize = rdata[PTE_PS];

  always_comb begin
    eval_done = 1'b0;
    eval_hit  = 1'b0;
    eval_wb   = 1'b0;
    eval_pa   = '0;
    case (op_q)
      OP_TRANSLATE: begin
        if (!pres) begin
          eval_done = 1'b1;
        end else if (lv_q == 2'd3 || ((lv_q == 2'd1 || lv_q == 2'd2) && psize)) begin
          eval_done = 1'b1;
          eval_hit  = 1'b1;
          eval_pa   = {rdata[51:12], 12'b0};
        end
      end
      OP_CHECK: begin
        case (lv_q)
          2'd0: begin
            eval_done = (rdata[11:0] & mask_q) == 12'b0;
          end
          2'd1: begin
            if (!pres) begin
              eval_done = 1'b1;
            end else if (type_q == MT_1G && psize) begin
              eval_done = 1'b1;
              eval_hit  = 1'b1;
            end
          end
          2'd2: begin
            // size bit is honoured before present here
            if (type_q == MT_2M && psize) begin
              eval_done = 1'b1;
              eval_hit  = 1'b1;
            end else if (!pres) begin
              eval_done = 1'b1;
            end
          end
          default: begin
            eval_done = 1'b1;
            eval_hit  = pres;
          end
        endcase
      end
      OP_UNMAP: begin
        if (!pres) begin
          eval_done = 1'b1;
        end else if (lv_q == 2'd3 || (lv_q == 2'd1 && type_q == MT_1G && psize) ||
                     (lv_q == 2'd2 && type_q == MT_2M && psize)) begin
          eval_done = 1'b1;
          eval_hit  = 1'b1;
          eval_wb   = 1'b1;
        end
      end
      default: begin
        eval_done = 1'b1;
      end
    endcase
  end

  assign res_load = (cmd_i.issue && issue_done) || (cmd_i.eval && eval_done);
  assign ram_re   = cmd_i.issue && !issue_done;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    if (cmd_i.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd_i.issue && op_q == OP_WRITE && w_in) begin
      ram_we    = 1'b1;
      ram_waddr = widx_ext[AW-1:0];
      ram_wdata = wdata_q;
    end else if (cmd_i.eval && eval_wb) begin
      ram_we    = 1'b1;
      ram_waddr = a_q;
      ram_wdata = {rdata[PTE_W-1:1], 1'b0};
    end
  end

  assign sts_o.clr_last   = clr_q == AW'(MEM_WORDS - 1);
  assign sts_o.issue_done = issue_done;
  assign sts_o.eval_done  = eval_done;

  assign phys_addr_o   = out_pa_q;
  assign hit_o         = out_hit_q;
  assign range_error_o = out_rerr_q;

  a_last_level_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && lv_q == 2'd3) |-> eval_done)
    else $error("walk ran past the last level");

  a_no_read_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.issue && oor) |-> !ram_re)
    else $error("read issued for a frame outside page memory");

  a_hit_excl_rerr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> !(res_hit_q && res_rerr_q))
    else $error("result flags both hit and range error");

endmodule

FILE: src/four_level_page_walker_unit.sv
// steps: a write item goes from accept through ISSUE (the memory write) and
//   RESP to the output register; a walk runs an ISSUE/EVAL pair per table
//   level, and ISSUE goes straight to RESP at a null or out-of-range pointer
// throughput: one item at a time, one ISSUE/EVAL pair per level on the single
//   page memory read port, next accept once the output register is loaded
// reset: async active low; then a clearing pass zeroes all PHYS_PAGES*512
//   page memory words with in_ready_o low; config writes are taken
module four_level_page_walker_unit #(
  parameter int unsigned PHYS_PAGES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fplw_pkg::ROOT_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  opcode_i,
  input  logic [fplw_pkg::VA_W-1:0]   virt_addr_i,
  input  logic [1:0]                  map_type_i,
  input  logic [11:0]                 flag_mask_i,
  input  logic [11:0]                 word_index_i,
  input  logic [fplw_pkg::PTE_W-1:0]  word_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fplw_pkg::PA_W-1:0]   phys_addr_o,
  output logic                        hit_o,
  output logic                        range_error_o
);
  import fplw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fplw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fplw_dp #(
    .PHYS_PAGES (PHYS_PAGES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .virt_addr_i   (virt_addr_i),
    .map_type_i    (map_type_i),
    .flag_mask_i   (flag_mask_i),
    .word_index_i  (word_index_i),
    .word_data_i   (word_data_i),
    .phys_addr_o   (phys_addr_o),
    .hit_o         (hit_o),
    .range_error_o (range_error_o)
  );

endmodule

FILE: tb/sv/tb_four_level_page_walker_unit.sv
`timescale 1ns / 100ps

module tb_four_level_page_walker_unit;
  import fplw_pkg::*;

  localparam int unsigned N_FRAMES  = 8;
  localparam int unsigned MEM_WORDS = N_FRAMES * PAGE_WORDS;
  // no leaf size answers to this type
  localparam logic [1:0] MT_NONE = 2'd3;
  localparam logic [VA_W-1:0] DIR_VA = 48'h0080_8060_4000;

  typedef struct packed {
    logic [PA_W-1:0] pa;
    logic            hit;
    logic            rerr;
  } walk_res_t;

  class walk_checker;
    logic [PTE_W-1:0] mem [MEM_WORDS];
    logic [ROOT_W-1:0] root;
    walk_res_t pending_results[$];
    int bad_results;

    function new();
      foreach (mem[i]) mem[i] = '0;
      root = '0;
      bad_results = 0;
    endfunction

    function void set_root(logic [ROOT_W-1:0] v);
      root = v;
    endfunction

    function walk_res_t predict_walk(logic [1:0] op, logic [VA_W-1:0] va, logic [1:0] mt,
                                     logic [11:0] mask, logic [11:0] widx,
                                     logic [PTE_W-1:0] wdata);
      logic [IDX_W-1:0] ix [4];
      logic [PTE_W-1:0] ent;
      logic [FRAME_W-1:0] frame;
      logic [11:0] addr;
      walk_res_t r;
      r = '0;
      ent = '0;
      if (op == OP_WRITE) begin
        if (widx < MEM_WORDS) mem[widx] = wdata;
        else r.rerr = 1'b1;
        return r;
      end
      ix[0] = va[47:39];
      ix[1] = va[38:30];
      ix[2] = va[29:21];
      ix[3] = va[20:12];
      frame = FRAME_W'(root);
      for (int lv = 0; lv < 4; lv++) begin
        if (lv > 0) begin
          frame = ent[51:12];
          // a null table pointer stops translate and check, not unmap
          if (op != OP_UNMAP && frame == '0) return r;
        end
        if (frame >= N_FRAMES) begin
          r.rerr = 1'b1;
          return r;
        end
        addr = {frame[2:0], ix[lv]};
        ent = mem[addr];
        case (op)
          OP_TRANSLATE: begin
            if (!ent[PTE_P]) return r;
            if (lv == 3 || ((lv == 1 || lv == 2) && ent[PTE_PS])) begin
              r.pa = {ent[51:12], 12'h000};
              r.hit = 1'b1;
              return r;
            end
          end
          OP_CHECK: begin
            if (lv == 0) begin
              if ((ent[11:0] & mask) == '0) return r;
            end else if (lv == 1) begin
              if (!ent[PTE_P]) return r;
              if (mt == MT_1G && ent[PTE_PS]) begin
                r.hit = 1'b1;
                return r;
              end
            end else if (lv == 2) begin
              // size bit looked at before present
              if (mt == MT_2M && ent[PTE_PS]) begin
                r.hit = 1'b1;
                return r;
              end
              if (!ent[PTE_P]) return r;
            end else begin
              r.hit = ent[PTE_P];
              return r;
            end
          end
          default: begin
            if (!ent[PTE_P]) return r;
            if (lv == 3 || (lv == 1 && mt == MT_1G && ent[PTE_PS]) ||
                (lv == 2 && mt == MT_2M && ent[PTE_PS])) begin
              mem[addr] = ent & ~(64'd1 << PTE_P);
              r.hit = 1'b1;
              return r;
            end
          end
        endcase
      end
      return r;
    endfunction

    function void note_input(logic [1:0] op, logic [VA_W-1:0] va, logic [1:0] mt,
                             logic [11:0] mask, logic [11:0] widx, logic [PTE_W-1:0] wdata);
      pending_results.push_back(predict_walk(op, va, mt, mask, widx, wdata));
    endfunction

    function void check_result(logic [PA_W-1:0] pa, logic hit, logic rerr);
      walk_res_t exp_r;
      if (pending_results.size() == 0) begin
        if (bad_results < 10)
          $display("unexpected result: pa=%h hit=%b range_error=%b", pa, hit, rerr);
        bad_results++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (exp_r.pa !== pa || exp_r.hit !== hit || exp_r.rerr !== rerr) begin
        if (bad_results < 10)
          $display("mismatch at %0t: exp pa=%h hit=%b range_error=%b, got pa=%h hit=%b range_error=%b",
                   $time, exp_r.pa, exp_r.hit, exp_r.rerr, pa, hit, rerr);
        bad_results++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ROOT_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        opcode_i;
  logic [VA_W-1:0]   virt_addr_i;
  logic [1:0]        map_type_i;
  logic [11:0]       flag_mask_i;
  logic [11:0]       word_index_i;
  logic [PTE_W-1:0]  word_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [PA_W-1:0]   phys_addr_o;
  logic              hit_o;
  logic              range_error_o;

  walk_checker sb = new();
  bit quiet;

  four_level_page_walker_unit #(
    .PHYS_PAGES(N_FRAMES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .virt_addr_i  (virt_addr_i),
    .map_type_i   (map_type_i),
    .flag_mask_i  (flag_mask_i),
    .word_index_i (word_index_i),
    .word_data_i  (word_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .phys_addr_o  (phys_addr_o),
    .hit_o        (hit_o),
    .range_error_o(range_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PTE_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [PTE_W-1:0] make_entry(logic [FRAME_W-1:0] fr, logic p, logic ps);
    logic [PTE_W-1:0] d;
    d = rand64();
    d[51:12] = fr;
    d[PTE_P] = p;
    d[PTE_PS] = ps;
    return d;
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame();
    logic [PTE_W-1:0] w;
    int r;
    r = $urandom_range(0, 99);
    w = rand64();
    if (r < 80) return FRAME_W'($urandom_range(1, N_FRAMES - 1));
    if (r < 88) return '0;
    if (r < 95) return FRAME_W'($urandom_range(N_FRAMES, 2 * N_FRAMES - 1));
    return w[FRAME_W-1:0];
  endfunction

  function automatic logic [1:0] pick_type();
    if ($urandom_range(0, 99) < 5) return MT_NONE;
    return 2'($urandom_range(0, 2));
  endfunction

  function automatic logic [11:0] pick_mask();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return 12'hFFF;
    return 12'($urandom());
  endfunction

  // receiving side, stalls of random length
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(phys_addr_o, hit_o, range_error_o);
  end

  // starts and ends at a falling edge, valid left high after the beat
  task automatic send_item(logic [1:0] op, logic [VA_W-1:0] va, logic [1:0] mt,
                           logic [11:0] mask, logic [11:0] widx, logic [PTE_W-1:0] wdata);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    virt_addr_i  <= va;
    map_type_i   <= mt;
    flag_mask_i  <= mask;
    word_index_i <= widx;
    word_data_i  <= wdata;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(op, va, mt, mask, widx, wdata);
    @(negedge clk_i);
  endtask

  task automatic write_word(logic [11:0] idx, logic [PTE_W-1:0] data);
    logic [PTE_W-1:0] va;
    va = rand64();
    send_item(OP_WRITE, va[VA_W-1:0], 2'($urandom()), 12'($urandom()), idx, data);
  endtask

  task automatic walk_op(logic [1:0] op, logic [VA_W-1:0] va, logic [1:0] mt, logic [11:0] mask);
    send_item(op, va, mt, mask, 12'($urandom()), rand64());
  endtask

  task automatic write_root(logic [ROOT_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    sb.set_root(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  // root 0: level words 1, 514, 1027, 1540 lie on the walk of DIR_VA
  task automatic directed_cases();
    walk_op(OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, MT_NONE, 12'hFFF);
    write_word(12'hFFF, '1);
    write_word(12'd1, make_entry(40'd1, 1'b1, 1'b0));
    write_word(12'd514, make_entry(40'd2, 1'b1, 1'b0));
    write_word(12'd1027, make_entry(40'd3, 1'b1, 1'b1));
    walk_op(OP_TRANSLATE, DIR_VA, MT_4K, 12'h000);
    walk_op(OP_CHECK, DIR_VA, MT_2M, 12'hFFF);
    walk_op(OP_CHECK, DIR_VA, MT_2M, 12'h000);
    // 2M leaf accepted by check on the size bit alone
    write_word(12'd1027, make_entry(40'd3, 1'b0, 1'b1));
    walk_op(OP_CHECK, DIR_VA, MT_2M, 12'h001);
    write_word(12'd1027, make_entry(40'd3, 1'b1, 1'b1));
    write_word(12'd1540, make_entry(40'd5, 1'b1, 1'b0));
    // size bit with another type: unmap goes through to the 4K leaf
    walk_op(OP_UNMAP, DIR_VA, MT_4K, pick_mask());
    walk_op(OP_CHECK, DIR_VA, MT_NONE, 12'hFFF);
    walk_op(OP_UNMAP, DIR_VA, MT_2M, pick_mask());
    // null pointer at level two
    write_word(12'd514, make_entry(40'd0, 1'b1, 1'b0));
    walk_op(OP_TRANSLATE, DIR_VA, MT_4K, pick_mask());
    walk_op(OP_UNMAP, DIR_VA, MT_4K, pick_mask());
    // frame beyond memory
    write_word(12'd1, make_entry(40'd9, 1'b1, 1'b0));
    walk_op(OP_TRANSLATE, DIR_VA, MT_4K, pick_mask());
    write_word(12'd1, make_entry(40'd1, 1'b1, 1'b0));
    write_word(12'd514, make_entry(40'd6, 1'b1, 1'b1));
    walk_op(OP_CHECK, DIR_VA, MT_1G, 12'hFFF);
    walk_op(OP_TRANSLATE, DIR_VA, MT_1G, pick_mask());
    walk_op(OP_UNMAP, DIR_VA, MT_1G, pick_mask());
    walk_op(OP_CHECK, DIR_VA, MT_1G, 12'hFFF);
  endtask

  // lay out a table path for a random address, then walk it
  task automatic walk_sequence();
    logic [PTE_W-1:0] w;
    logic [VA_W-1:0] va;
    logic [FRAME_W-1:0] fr;
    logic [FRAME_W-1:0] nxt;
    logic [IDX_W-1:0] ix;
    int depth;
    int pct;
    logic [1:0] op;
    w = rand64();
    va = w[VA_W-1:0];
    fr = FRAME_W'(sb.root);
    depth = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 4;
    for (int lv = 0; lv < depth; lv++) begin
      if (fr >= N_FRAMES) break;
      ix = va[47 - 9 * lv -: 9];
      nxt = pick_frame();
      pct = (lv == 1 || lv == 2) ? 30 : 10;
      write_word({fr[2:0], ix},
                 make_entry(nxt, $urandom_range(0, 9) != 0, $urandom_range(0, 99) < pct));
      fr = nxt;
    end
    repeat ($urandom_range(1, 3)) begin
      op = 2'($urandom_range(1, 3));
      walk_op(op, va, pick_type(), pick_mask());
    end
  endtask

  task automatic run_phase(int n_items, ref int sent);
    logic [PTE_W-1:0] w;
    int r;
    int start;
    start = sent;
    while (sent - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        walk_sequence();
      end else if (r < 85) begin
        write_word(12'($urandom()), rand64());
        sent++;
      end else begin
        w = rand64();
        walk_op(2'($urandom_range(1, 3)), w[VA_W-1:0], pick_type(), pick_mask());
        sent++;
      end
      // a sequence is about six beats
      if (r < 70) sent += 6;
    end
  endtask

  initial begin
    int sent;
    logic [ROOT_W-1:0] roots [5];
    sent = 0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    opcode_i = OP_WRITE;
    virt_addr_i = '0;
    map_type_i = MT_4K;
    flag_mask_i = '0;
    word_index_i = '0;
    word_data_i = '0;
    roots[0] = 3'd7;
    roots[1] = 3'd0;
    roots[2] = 3'($urandom_range(1, 6));
    roots[3] = 3'd7;
    roots[4] = 3'($urandom());
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_root(3'd0);
    directed_cases();
    run_phase(300, sent);
    foreach (roots[i]) begin
      drain();
      write_root(roots[i]);
      quiet = ($urandom_range(0, 3) == 0);
      run_phase(310, sent);
    end
    drain();
    if (sb.bad_results == 0 && sb.pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
